// ===== design/blackman_harris_window_weight_assert.svh =====
// assertion macros shared by the window weight rtl
`ifndef BLACKMAN_HARRIS_WINDOW_WEIGHT_ASSERT_SVH
`define BLACKMAN_HARRIS_WINDOW_WEIGHT_ASSERT_SVH

`ifndef ASSERT_OFF
// property checked out of reset
`define BHWW_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("bhww assertion failed");
// property checked during reset as well
`define BHWW_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("bhww assertion failed");
`else
`define BHWW_ASSERT(label, prop)
`define BHWW_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== design/bhww_pkg.sv =====
package bhww_pkg;

  localparam int unsigned IndexW  = 16;
  localparam int unsigned SizeW   = 17;
  localparam int unsigned WeightW = 18;
  localparam int unsigned PhaseW  = 24;
  localparam int unsigned RomW    = 18;
  localparam int unsigned CosW    = 19;
  localparam int unsigned CoefW   = 25;
  localparam int unsigned ProdW   = CoefW + CosW;
  localparam int unsigned AccW    = ProdW + 2;

  localparam logic [SizeW-1:0]   SizeReset = SizeW'(1024);
  localparam logic [WeightW-1:0] OneQ17    = WeightW'(131072);

  localparam longint unsigned HalfPiQ30 = 64'd1686629713;

  // coefficients in q24, rounded
  localparam longint Coef0 = ((longint'(35875) <<< 24) + 50000) / 100000;
  localparam longint Coef1 = ((longint'(48829) <<< 24) + 50000) / 100000;
  localparam longint Coef2 = ((longint'(14128) <<< 24) + 50000) / 100000;
  localparam longint Coef3 = ((longint'(1168) <<< 24) + 50000) / 100000;

  // constant term of the sum in q41
  localparam longint Bias = Coef0 * 131072;

endpackage

// ===== design/blackman_harris_window_weight.sv =====
// Four-term Blackman-Harris window weight generator. Give it a bin index n and it returns
// w = 0.35875 - 0.48829cos(x) + 0.14128cos(2x) - 0.01168cos(3x), x = 2*pi*n/(N-1), as an
// unsigned Q1.17 weight clamped to [0, 1.0]; N comes from the window size register (reset
// 1024, saturated at MAX_WINDOW_SIZE). An index at or past N sets out_of_range_o and gives
// weight 0. The pipeline takes one index per cycle and returns one result per index in order;
// its stages in order are an input register, 25 bit-per-stage restoring divider stages that form
// the 24-bit phase n/(N-1), then phase multiples, table address rounding, quadrant folding,
// the registered quarter-wave cosine ROM read, coefficient products and the final sum with
// clamping into the output register. The whole pipeline halts while a result waits unread.
// The window size may only be written while no transfer is in flight.
`include "blackman_harris_window_weight_assert.svh"

module blackman_harris_window_weight #(
  parameter int unsigned MAX_WINDOW_SIZE = 65536,
  parameter int unsigned COS_TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bhww_pkg::SizeW-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [bhww_pkg::IndexW-1:0]       bin_index_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bhww_pkg::WeightW-1:0]      weight_o,
  output logic                              out_of_range_o
);

  localparam int unsigned SizeW   = bhww_pkg::SizeW;
  localparam int unsigned PhaseW  = bhww_pkg::PhaseW;
  localparam int unsigned RomW    = bhww_pkg::RomW;
  localparam int unsigned CosW    = bhww_pkg::CosW;
  localparam int unsigned CoefW   = bhww_pkg::CoefW;
  localparam int unsigned ProdW   = bhww_pkg::ProdW;
  localparam int unsigned AccW    = bhww_pkg::AccW;
  localparam int unsigned WeightW = bhww_pkg::WeightW;
  localparam int unsigned DivSteps = PhaseW + 1;
  localparam int unsigned RemW    = SizeW + 1;
  localparam int unsigned FullCnt = 4 * COS_TABLE_DEPTH;
  localparam int unsigned KW      = $clog2(FullCnt + 1);
  localparam int unsigned MulW    = PhaseW + KW;
  localparam int unsigned AddrW   = $clog2(COS_TABLE_DEPTH + 1);

  typedef logic [RomW-1:0] cos_rom_t [0:COS_TABLE_DEPTH];

  // cos(i*pi/(2*depth)) in q17 from an integer taylor series in q30
  function automatic logic [RomW-1:0] quarter_cos(input int unsigned i);
    logic [63:0]        theta;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    logic [63:0]        v;
    theta = (64'(i) * bhww_pkg::HalfPiQ30 + 64'(COS_TABLE_DEPTH / 2))
            / 64'(COS_TABLE_DEPTH);
    x2    = (theta * theta) >> 30;
    term  = 64'd1 << 30;
    sum   = signed'(term);
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k - 1) * (2 * k));
      if ((k % 2) == 1) sum = sum - signed'(term);
      else              sum = sum + signed'(term);
    end
    if (sum <= 0) return '0;
    v = (unsigned'(sum) + 64'd4096) >> 13;
    if (v > 64'(bhww_pkg::OneQ17)) v = 64'(bhww_pkg::OneQ17);
    return v[RomW-1:0];
  endfunction

  function automatic cos_rom_t build_rom();
    cos_rom_t t;
    for (int unsigned i = 0; i <= COS_TABLE_DEPTH; i++) t[i] = quarter_cos(i);
    return t;
  endfunction

  localparam cos_rom_t CosRom = build_rom();

  // pipeline advances as a whole unless the output holds an untaken result
  logic pipe_en;
  logic out_valid_q;
  assign pipe_en    = !out_valid_q || out_ready_i;
  assign in_ready_o = pipe_en;

  // window size register
  logic [SizeW-1:0] window_size_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_size_q <= bhww_pkg::SizeReset;
    end else if (cfg_we_i) begin
      window_size_q <= cfg_wdata_i;
    end
  end

  // effective size, clamped to the build-time maximum
  logic [SizeW-1:0] size_eff;
  always_comb begin
    size_eff = window_size_q;
    if (32'(window_size_q) > 32'(MAX_WINDOW_SIZE)) size_eff = SizeW'(MAX_WINDOW_SIZE);
  end

  // divider pipeline, entry 0 is the input register
  logic               dv_vld_q [0:DivSteps];
  logic               dv_oor_q [0:DivSteps];
  logic               dv_one_q [0:DivSteps];
  logic [SizeW-1:0]   dv_div_q [0:DivSteps];
  logic [RemW-1:0]    dv_rem_q [0:DivSteps];
  logic [PhaseW:0]    dv_quo_q [0:DivSteps];
  logic [RemW-1:0]    dv_rem_d [1:DivSteps];
  logic [PhaseW:0]    dv_quo_d [1:DivSteps];

  // one quotient bit per stage; the first stage takes the integer bit
  always_comb begin
    for (int j = 1; j <= DivSteps; j++) begin
      logic [RemW-1:0] t;
      logic            ge;
      t  = (j == 1) ? dv_rem_q[j-1] : {dv_rem_q[j-1][RemW-2:0], 1'b0};
      ge = t >= {1'b0, dv_div_q[j-1]};
      dv_rem_d[j] = ge ? t - {1'b0, dv_div_q[j-1]} : t;
      dv_quo_d[j] = {dv_quo_q[j-1][PhaseW-1:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j <= DivSteps; j++) dv_vld_q[j] <= 1'b0;
    end else if (pipe_en) begin
      dv_vld_q[0] <= in_valid_i;
      for (int j = 1; j <= DivSteps; j++) dv_vld_q[j] <= dv_vld_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      dv_oor_q[0] <= SizeW'(bin_index_i) >= size_eff;
      dv_one_q[0] <= size_eff == SizeW'(1);
      dv_div_q[0] <= size_eff - SizeW'(1);
      dv_rem_q[0] <= RemW'(bin_index_i);
      dv_quo_q[0] <= '0;
      for (int j = 1; j <= DivSteps; j++) begin
        dv_oor_q[j] <= dv_oor_q[j-1];
        dv_one_q[j] <= dv_one_q[j-1];
        dv_div_q[j] <= dv_div_q[j-1];
        dv_rem_q[j] <= dv_rem_d[j];
        dv_quo_q[j] <= dv_quo_d[j];
      end
    end
  end

  // stage a: phase and its multiples, modulo one
  logic              vld_a_q, vld_b_q, vld_c_q, vld_d_q, vld_e_q;
  logic              oor_a_q, oor_b_q, oor_c_q, oor_d_q, oor_e_q, oor_q;
  logic [PhaseW-1:0] ph_a_q [0:2];
  logic [PhaseW-1:0] ph_d;
  always_comb begin
    ph_d = dv_one_q[DivSteps] ? '0 : dv_quo_q[DivSteps][PhaseW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      oor_a_q   <= dv_oor_q[DivSteps];
      ph_a_q[0] <= ph_d;
      ph_a_q[1] <= {ph_d[PhaseW-2:0], 1'b0};
      ph_a_q[2] <= ph_d + {ph_d[PhaseW-2:0], 1'b0};
    end
  end

  // stage b: round phase to a table step
  logic [KW-1:0] k_b_q [0:2];
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      oor_b_q <= oor_a_q;
      for (int j = 0; j < 3; j++) begin
        k_b_q[j] <= KW'((MulW'(ph_a_q[j]) * MulW'(FullCnt)
                        + (MulW'(1) << (PhaseW - 1))) >> PhaseW);
      end
    end
  end

  // stage c: fold quadrant into a quarter-wave address and sign
  logic [AddrW-1:0] addr_c_q [0:2];
  logic             neg_c_q  [0:2];
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      oor_c_q <= oor_b_q;
      for (int j = 0; j < 3; j++) begin
        logic [KW-1:0] kk;
        logic [1:0]    quad;
        logic [KW-1:0] r;
        kk = (k_b_q[j] == KW'(FullCnt)) ? '0 : k_b_q[j];
        if (kk >= KW'(3 * COS_TABLE_DEPTH)) begin
          quad = 2'd3;
          r    = kk - KW'(3 * COS_TABLE_DEPTH);
        end else if (kk >= KW'(2 * COS_TABLE_DEPTH)) begin
          quad = 2'd2;
          r    = kk - KW'(2 * COS_TABLE_DEPTH);
        end else if (kk >= KW'(COS_TABLE_DEPTH)) begin
          quad = 2'd1;
          r    = kk - KW'(COS_TABLE_DEPTH);
        end else begin
          quad = 2'd0;
          r    = kk;
        end
        addr_c_q[j] <= quad[0] ? AddrW'(KW'(COS_TABLE_DEPTH) - r) : AddrW'(r);
        neg_c_q[j]  <= quad[0] ^ quad[1];
      end
    end
  end

  // stage d: registered rom read, one port per cosine
  logic [RomW-1:0] rom_d_q [0:2];
  logic            neg_d_q [0:2];
  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      oor_d_q <= oor_c_q;
      for (int j = 0; j < 3; j++) begin
        rom_d_q[j] <= CosRom[addr_c_q[j]];
        neg_d_q[j] <= neg_c_q[j];
      end
    end
  end

  // stage e: coefficient products in q41
  logic signed [ProdW-1:0] prod_e_q [0:2];
  logic signed [CosW-1:0]  cosv [0:2];
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cosv[j] = neg_d_q[j] ? -signed'(CosW'(rom_d_q[j])) : signed'(CosW'(rom_d_q[j]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      oor_e_q     <= oor_d_q;
      prod_e_q[0] <= signed'(CoefW'(bhww_pkg::Coef1)) * cosv[0];
      prod_e_q[1] <= signed'(CoefW'(bhww_pkg::Coef2)) * cosv[1];
      prod_e_q[2] <= signed'(CoefW'(bhww_pkg::Coef3)) * cosv[2];
    end
  end

  // stage f: sum, round to q17, clamp
  logic signed [AccW-1:0] acc;
  logic [AccW-1:0]        acc_rnd;
  logic [WeightW-1:0]     weight_d;
  logic [WeightW-1:0]     weight_q;
  always_comb begin
    acc = signed'(AccW'(bhww_pkg::Bias)) - AccW'(prod_e_q[0]) + AccW'(prod_e_q[1])
          - AccW'(prod_e_q[2]);
    acc_rnd = (unsigned'(acc) + (AccW'(1) << (PhaseW - 1))) >> PhaseW;
    if (acc <= 0 || oor_e_q) begin
      weight_d = '0;
    end else if (acc_rnd > AccW'(bhww_pkg::OneQ17)) begin
      weight_d = bhww_pkg::OneQ17;
    end else begin
      weight_d = acc_rnd[WeightW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      weight_q <= weight_d;
      oor_q    <= oor_e_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_a_q     <= 1'b0;
      vld_b_q     <= 1'b0;
      vld_c_q     <= 1'b0;
      vld_d_q     <= 1'b0;
      vld_e_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (pipe_en) begin
      vld_a_q     <= dv_vld_q[DivSteps];
      vld_b_q     <= vld_a_q;
      vld_c_q     <= vld_b_q;
      vld_d_q     <= vld_c_q;
      vld_e_q     <= vld_d_q;
      out_valid_q <= vld_e_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign weight_o       = weight_q;
  assign out_of_range_o = oor_q;

  // out of range results carry zero weight
  `BHWW_ASSERT(a_oor_zero, out_valid_o && out_of_range_o |-> weight_o == '0)
  // weight never exceeds one
  `BHWW_ASSERT(a_weight_max, out_valid_o |-> weight_o <= bhww_pkg::OneQ17)
  // a stall freezes the in-flight valid bits, checked here on stages a and e
  `BHWW_ASSERT(a_stall_hold, !pipe_en |=> $stable(vld_e_q) && $stable(vld_a_q))
  // nothing is in flight right after reset
  `BHWW_ASSERT_ALWAYS(a_rst_empty, !rst_ni |-> !out_valid_q && !vld_e_q)

endmodule
